/* hdl/rainflow_cycle_counter_macros.svh */
// Assertion macros shared by the rainflow cycle counter modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RAINFLOW_CYCLE_COUNTER_MACROS_SVH
`define RAINFLOW_CYCLE_COUNTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rcc_pkg.sv */
`default_nettype none

package rcc_pkg;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned RANGE_WIDTH  = 16;
  localparam int unsigned CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W        = $clog2(STACK_DEPTH);

  // The command queue depth must be a power of two so the pointers wrap.
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SAMPLE_WIDTH:0]          diff_t;
  typedef logic [RANGE_WIDTH-1:0]         range_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [QPTR_W-1:0]              qptr_t;
  typedef logic [QCNT_W-1:0]              qcnt_t;

  localparam cnt_t STACK_FULL = cnt_t'(STACK_DEPTH);
  localparam cnt_t RULE_MIN   = cnt_t'(3);

  // Work handed from the front end to the back end for one sample.
  typedef struct packed {
    logic    do_push;
    sample_t push_val;
    logic    do_end;
    sample_t end_val;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PUSH,
    B_RULE,
    B_RD,
    B_CMP,
    B_SHIFT,
    B_END_PUSH,
    B_FL_RD,
    B_FL_EM,
    B_FINISH
  } back_state_e;

  function automatic diff_t abs_diff(sample_t a, sample_t b);
    logic signed [SAMPLE_WIDTH:0] d;
    d = {a[SAMPLE_WIDTH-1], a} - {b[SAMPLE_WIDTH-1], b};
    return d[SAMPLE_WIDTH] ? diff_t'(-d) : diff_t'(d);
  endfunction

  function automatic range_t to_range(diff_t d);
    return range_t'(d);
  endfunction

endpackage

`default_nettype wire

/* hdl/rcc_ram.sv */
`default_nettype none

module rcc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

/* hdl/rcc_front.sv */
`default_nettype none

module rcc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rcc_pkg::sample_t sample_i,
  input  logic             end_of_series_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output rcc_pkg::cmd_t    q_data_o
);

  logic [1:0]       seen_q, seen_d;
  rcc_pkg::sample_t prev_q, prev_d;
  rcc_pkg::sample_t cand_q, cand_d;
  logic signed [rcc_pkg::SAMPLE_WIDTH:0] s1, s2;
  logic turn;
  logic accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1 = {cand_q[rcc_pkg::SAMPLE_WIDTH-1], cand_q} - {prev_q[rcc_pkg::SAMPLE_WIDTH-1], prev_q};
    s2 = {sample_i[rcc_pkg::SAMPLE_WIDTH-1], sample_i}
       - {cand_q[rcc_pkg::SAMPLE_WIDTH-1], cand_q};
    // The candidate is a turning point when the slope into it is not flat and
    // the slope out of it is flat or has the opposite sign.
    turn = (s1 != '0) && ((s2 == '0) || (s1[rcc_pkg::SAMPLE_WIDTH] != s2[rcc_pkg::SAMPLE_WIDTH]));

    q_data_o.do_push  = ((seen_q == 2'd0) && !end_of_series_i) || (seen_q[1] && turn);
    q_data_o.push_val = (seen_q == 2'd0) ? sample_i : cand_q;
    q_data_o.do_end   = end_of_series_i;
    q_data_o.end_val  = sample_i;
    q_push_o          = accept && (q_data_o.do_push || q_data_o.do_end);

    seen_d = seen_q;
    prev_d = prev_q;
    cand_d = cand_q;
    if (accept) begin
      if (end_of_series_i) begin
        seen_d = 2'd0;
        prev_d = '0;
        cand_d = '0;
      end else begin
        prev_d = cand_q;
        cand_d = sample_i;
        seen_d = seen_q[1] ? seen_q : seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
      prev_q <= '0;
      cand_q <= '0;
    end else begin
      seen_q <= seen_d;
      prev_q <= prev_d;
      cand_q <= cand_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/rcc_cmd_fifo.sv */
`default_nettype none
`include "rainflow_cycle_counter_macros.svh"

module rcc_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rcc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rcc_pkg::cmd_t data_o
);

  rcc_pkg::cmd_t  mem_q [rcc_pkg::QUEUE_DEPTH];
  rcc_pkg::qptr_t wptr_q, wptr_d;
  rcc_pkg::qptr_t rptr_q, rptr_d;
  rcc_pkg::qcnt_t cnt_q, cnt_d;

  assign full_o  = (cnt_q == rcc_pkg::qcnt_t'(rcc_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + rcc_pkg::qptr_t'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + rcc_pkg::qptr_t'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + rcc_pkg::qcnt_t'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - rcc_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  `RCC_ASSERT_IMPL(a_push_has_room, push_i, !full_o, "command queue written while full")
  `RCC_ASSERT_IMPL(a_pop_has_entry, pop_i, !empty_o, "command queue read while empty")
  `RCC_ASSERT_NEXT(a_push_not_lost, push_i && !pop_i, !empty_o, "queued command vanished")

endmodule

`default_nettype wire

/* hdl/rcc_back.sv */
`default_nettype none
`include "rainflow_cycle_counter_macros.svh"

module rcc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  rcc_pkg::cmd_t   q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rcc_pkg::range_t cycle_range_o,
  output logic            is_full_cycle_o,
  output logic            last_of_run_o,
  output logic            stack_overflow_o
);

  rcc_pkg::back_state_e state_q, state_d;
  rcc_pkg::cmd_t        cmd_q, cmd_d;
  rcc_pkg::cnt_t        cnt_q, cnt_d;
  rcc_pkg::cnt_t        idx_q, idx_d;
  logic                 ovf_q, ovf_d;
  rcc_pkg::sample_t     pa_q, pa_d;
  rcc_pkg::sample_t     pb_q, pb_d;
  rcc_pkg::diff_t       x_q, x_d;

  // One finished result waits here until it is known whether it is the last
  // one of its sample.
  logic                 hold_v_q, hold_v_d;
  rcc_pkg::range_t      hold_range_q, hold_range_d;
  logic                 hold_full_q, hold_full_d;
  logic                 hold_ovf_q, hold_ovf_d;

  logic                 out_v_q, out_v_d;
  rcc_pkg::range_t      out_range_q;
  logic                 out_full_q;
  logic                 out_last_q;
  logic                 out_ovf_q;

  rcc_pkg::cnt_t        cm1, cm2, cm3, idx_p1;
  rcc_pkg::diff_t       y, r;
  rcc_pkg::sample_t     rdata_a, rdata_b, wdata;
  logic [rcc_pkg::PTR_W-1:0] raddr_a, raddr_b, waddr;
  logic                 we;
  logic                 out_free, emit_ok, emit, close, move;
  rcc_pkg::range_t      emit_range;
  logic                 emit_full;

  rcc_ram #(
    .Width(rcc_pkg::SAMPLE_WIDTH),
    .Depth(rcc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign cm1    = cnt_q - rcc_pkg::cnt_t'(1);
  assign cm2    = cnt_q - rcc_pkg::cnt_t'(2);
  assign cm3    = cnt_q - rcc_pkg::cnt_t'(3);
  assign idx_p1 = idx_q + rcc_pkg::cnt_t'(1);

  assign out_free = !out_v_q || out_ready_i;
  assign emit_ok  = !hold_v_q || out_free;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    ovf_d      = ovf_q;
    pa_d       = pa_q;
    pb_d       = pb_q;
    x_d        = x_q;
    q_pop_o    = 1'b0;
    we         = 1'b0;
    waddr      = cnt_q[rcc_pkg::PTR_W-1:0];
    wdata      = cmd_q.push_val;
    raddr_a    = cm1[rcc_pkg::PTR_W-1:0];
    raddr_b    = cm2[rcc_pkg::PTR_W-1:0];
    emit       = 1'b0;
    emit_range = '0;
    emit_full  = 1'b0;
    close      = 1'b0;
    y          = rcc_pkg::abs_diff(pb_q, rdata_a);
    r          = rcc_pkg::abs_diff(rdata_a, rdata_b);

    unique case (state_q)
      rcc_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          state_d = q_data_i.do_push ? rcc_pkg::B_PUSH : rcc_pkg::B_END_PUSH;
        end
      end
      rcc_pkg::B_PUSH: begin
        if (cnt_q < rcc_pkg::STACK_FULL) begin
          we    = 1'b1;
          cnt_d = cnt_q + rcc_pkg::cnt_t'(1);
        end else begin
          ovf_d = 1'b1;
        end
        state_d = rcc_pkg::B_RULE;
      end
      rcc_pkg::B_RULE: begin
        if (cnt_q >= rcc_pkg::RULE_MIN) begin
          state_d = rcc_pkg::B_RD;
        end else begin
          state_d = cmd_q.do_end ? rcc_pkg::B_END_PUSH : rcc_pkg::B_FINISH;
        end
      end
      rcc_pkg::B_RD: begin
        pa_d    = rdata_a;
        pb_d    = rdata_b;
        x_d     = rcc_pkg::abs_diff(rdata_a, rdata_b);
        raddr_a = cm3[rcc_pkg::PTR_W-1:0];
        state_d = rcc_pkg::B_CMP;
      end
      rcc_pkg::B_CMP: begin
        raddr_a = cm3[rcc_pkg::PTR_W-1:0];
        if ((x_q >= y) && (y != '0)) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_range = rcc_pkg::to_range(y);
            we         = 1'b1;
            if (cnt_q == rcc_pkg::RULE_MIN) begin
              // The range starts at the bottom of the stack: half cycle, and
              // the bottom point is dropped by moving the other two down.
              emit_full = 1'b0;
              waddr     = '0;
              wdata     = pb_q;
              cnt_d     = rcc_pkg::cnt_t'(2);
              state_d   = rcc_pkg::B_SHIFT;
            end else begin
              emit_full = 1'b1;
              waddr     = cm3[rcc_pkg::PTR_W-1:0];
              wdata     = pa_q;
              cnt_d     = cm2;
              state_d   = rcc_pkg::B_RULE;
            end
          end
        end else begin
          state_d = cmd_q.do_end ? rcc_pkg::B_END_PUSH : rcc_pkg::B_FINISH;
        end
      end
      rcc_pkg::B_SHIFT: begin
        we      = 1'b1;
        waddr   = rcc_pkg::PTR_W'(1);
        wdata   = pa_q;
        state_d = rcc_pkg::B_RULE;
      end
      rcc_pkg::B_END_PUSH: begin
        wdata = cmd_q.end_val;
        if (cnt_q < rcc_pkg::STACK_FULL) begin
          we    = 1'b1;
          cnt_d = cnt_q + rcc_pkg::cnt_t'(1);
        end else begin
          ovf_d = 1'b1;
        end
        idx_d   = '0;
        state_d = rcc_pkg::B_FL_RD;
      end
      rcc_pkg::B_FL_RD: begin
        raddr_a = idx_q[rcc_pkg::PTR_W-1:0];
        raddr_b = idx_p1[rcc_pkg::PTR_W-1:0];
        if (idx_p1 < cnt_q) begin
          state_d = rcc_pkg::B_FL_EM;
        end else begin
          // The residue is flushed: the next sample starts a new series.
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = rcc_pkg::B_FINISH;
        end
      end
      rcc_pkg::B_FL_EM: begin
        raddr_a = idx_q[rcc_pkg::PTR_W-1:0];
        raddr_b = idx_p1[rcc_pkg::PTR_W-1:0];
        if (r != '0) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_range = rcc_pkg::to_range(r);
            emit_full  = 1'b0;
            idx_d      = idx_p1;
            state_d    = rcc_pkg::B_FL_RD;
          end
        end else begin
          idx_d   = idx_p1;
          state_d = rcc_pkg::B_FL_RD;
        end
      end
      rcc_pkg::B_FINISH: begin
        if (!hold_v_q || out_free) begin
          close   = 1'b1;
          state_d = rcc_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = rcc_pkg::B_IDLE;
      end
    endcase
  end

  // A new result pushes the held one out as not last; closing a command
  // pushes it out as the last of its sample.
  always_comb begin
    move         = hold_v_q && (emit || close);
    hold_v_d     = hold_v_q;
    hold_range_d = hold_range_q;
    hold_full_d  = hold_full_q;
    hold_ovf_d   = hold_ovf_q;
    if (emit) begin
      hold_v_d     = 1'b1;
      hold_range_d = emit_range;
      hold_full_d  = emit_full;
      hold_ovf_d   = ovf_q;
    end else if (close) begin
      hold_v_d = 1'b0;
    end
    out_v_d = move || (out_v_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rcc_pkg::B_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pa_q         <= pa_d;
    pb_q         <= pb_d;
    x_q          <= x_d;
    hold_range_q <= hold_range_d;
    hold_full_q  <= hold_full_d;
    hold_ovf_q   <= hold_ovf_d;
    if (move) begin
      out_range_q <= hold_range_q;
      out_full_q  <= hold_full_q;
      out_ovf_q   <= hold_ovf_q;
      out_last_q  <= close;
    end
  end

  assign out_valid_o      = out_v_q;
  assign cycle_range_o    = out_range_q;
  assign is_full_cycle_o  = out_full_q;
  assign last_of_run_o    = out_last_q;
  assign stack_overflow_o = out_ovf_q;

  `RCC_ASSERT_IMPL(a_move_into_free, move, !out_v_q || out_ready_i, "result overwrote output")
  `RCC_ASSERT_IMPL(a_rule_depth, state_q == rcc_pkg::B_RD, cnt_q >= rcc_pkg::RULE_MIN, "rule on short stack")
  `RCC_ASSERT_IMPL(a_idle_drained, state_q == rcc_pkg::B_IDLE, !hold_v_q, "result held while idle")

endmodule

`default_nettype wire

/* hdl/rainflow_cycle_counter.sv */
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  sample_i, end_of_series_i
// result    out        out_valid_o/out_ready_i cycle_range_o, is_full_cycle_o,
//                                              last_of_run_o, stack_overflow_o
//
// Samples are taken one a cycle while the four-entry command queue has room; only the
// first sample of a series, turning points and series ends reach the back end. It pops a
// command, pushes each point and runs the rule test (skipped under three points; a half
// cycle drops the bottom point), pushes the end sample of a series, emits each residual
// pair, ends the flush and closes the sample. Reset clears the control state but not the
// stack RAM. A stalled result holds the back end, so the queue fills and in_ready_o drops.
`default_nettype none

module rainflow_cycle_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [rcc_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                         end_of_series_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rcc_pkg::RANGE_WIDTH-1:0] cycle_range_o,
  output logic                         is_full_cycle_o,
  output logic                         last_of_run_o,
  output logic                         stack_overflow_o
);

  rcc_pkg::cmd_t push_data;
  rcc_pkg::cmd_t pop_data;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;

  rcc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .end_of_series_i(end_of_series_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (push_data)
  );

  rcc_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (push_data),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (pop_data)
  );

  rcc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (pop_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cycle_range_o   (cycle_range_o),
    .is_full_cycle_o (is_full_cycle_o),
    .last_of_run_o   (last_of_run_o),
    .stack_overflow_o(stack_overflow_o)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PER_SAMPLE = 64;

  typedef struct {
    rcc_pkg::range_t span;
    logic            full;
    logic            last;
    logic            ovf;
  } cycle_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  rcc_pkg::sample_t sample_i;
  logic             end_of_series_i;
  logic             out_valid_o;
  logic             out_ready_i;
  rcc_pkg::range_t  cycle_range_o;
  logic             is_full_cycle_o;
  logic             last_of_run_o;
  logic             stack_overflow_o;

  // Expected cycles in the order the block must report them.
  cycle_t cycle_q[$];

  // Predictor state: turning point stack and slope tracking.
  int   turn_pts[rcc_pkg::STACK_DEPTH];
  int   turn_cnt;
  int   prior_val;
  int   cand_val;
  int   seen_cnt;
  logic ovf_flag;
  int   step_cnt;

  int err_cnt;
  int items_sent;
  int cycles_seen;
  int full_seen;
  int ovf_results;
  int send_idle_pct;
  int recv_idle_pct;

  rainflow_cycle_counter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .end_of_series_i (end_of_series_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cycle_range_o   (cycle_range_o),
    .is_full_cycle_o (is_full_cycle_o),
    .last_of_run_o   (last_of_run_o),
    .stack_overflow_o(stack_overflow_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int span_of(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void record_cycle(int span, logic full);
    cycle_t c;
    if (step_cnt < MAX_PER_SAMPLE) begin
      c.span = rcc_pkg::range_t'(span);
      c.full = full;
      c.last = 1'b0;
      c.ovf  = ovf_flag;
      cycle_q.insert(cycle_q.size(), c);
      step_cnt++;
    end
  endfunction

  function automatic void push_turn(int v);
    if (turn_cnt >= rcc_pkg::STACK_DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      turn_pts[turn_cnt] = v;
      turn_cnt++;
    end
  endfunction

  // Extract cycles while the newest range covers the one before it.
  function automatic void apply_astm();
    int c;
    int x;
    int y;
    bit done;
    done = 1'b0;
    while (!done && turn_cnt >= 3) begin
      c = turn_cnt;
      x = span_of(turn_pts[c-1], turn_pts[c-2]);
      y = span_of(turn_pts[c-2], turn_pts[c-3]);
      if (x < y || y == 0) begin
        done = 1'b1;
      end else if (c == 3) begin
        record_cycle(y, 1'b0);
        turn_pts[0] = turn_pts[1];
        turn_pts[1] = turn_pts[2];
        turn_cnt = 2;
      end else begin
        record_cycle(y, 1'b1);
        turn_pts[c-3] = turn_pts[c-1];
        turn_cnt = c - 2;
      end
    end
  endfunction

  function automatic void predict_cycles(rcc_pkg::sample_t smp, logic eos);
    int  v;
    int  s1;
    int  s2;
    int  i;
    bit  turn;
    v = int'(smp);
    step_cnt = 0;
    if (seen_cnt == 0) begin
      if (!eos) push_turn(v);
    end else if (seen_cnt >= 2) begin
      s1 = cand_val - prior_val;
      s2 = v - cand_val;
      turn = (s1 != 0) && (s2 == 0 || ((s1 > 0) != (s2 > 0)));
      if (turn) begin
        push_turn(cand_val);
        apply_astm();
      end
    end
    if (eos) begin
      push_turn(v);
      for (i = 0; i + 1 < turn_cnt; i++) begin
        if (span_of(turn_pts[i], turn_pts[i+1]) > 0)
          record_cycle(span_of(turn_pts[i], turn_pts[i+1]), 1'b0);
      end
      turn_cnt  = 0;
      seen_cnt  = 0;
      ovf_flag  = 1'b0;
      prior_val = 0;
      cand_val  = 0;
    end else begin
      prior_val = cand_val;
      cand_val  = v;
      if (seen_cnt < 2) seen_cnt++;
    end
    if (step_cnt > 0) cycle_q[cycle_q.size()-1].last = 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input rcc_pkg::sample_t smp, input logic eos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    sample_i        <= smp;
    end_of_series_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    predict_cycles(smp, eos);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (cycle_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin : check_results
    cycle_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cycle_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual range %0d full %0b last %0b",
                 $time, cycle_range_o, is_full_cycle_o, last_of_run_o);
      end else begin
        want = cycle_q.pop_front();
        check_field("cycle_range", want.span, cycle_range_o);
        check_field("is_full_cycle", want.full, is_full_cycle_o);
        check_field("last_of_run", want.last, last_of_run_o);
        check_field("stack_overflow", want.ovf, stack_overflow_o);
        cycles_seen++;
        if (want.full) full_seen++;
        if (want.ovf) ovf_results++;
      end
    end
  end

  task automatic test_single_samples();
    send_sample(16'sd1234, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  task automatic test_extremes();
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);
  endtask

  // A plateau must create only one turning point, not one per repeated sample; the last sample repeats.
  task automatic test_flat_stretches();
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd9, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd4, 1'b0);
    send_sample(16'sd4, 1'b1);
  endtask

  // Exercises both the half cycle at the stack bottom and full cycles.
  task automatic test_cycle_rules();
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd8, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd3, 1'b1);
  endtask

  // A decaying oscillation never satisfies the rule, so the stack fills.
  task automatic test_stack_overflow();
    int k;
    int amp;
    for (k = 0; k < 40; k++) begin
      amp = 20000 - k * 400;
      send_sample(rcc_pkg::sample_t'((k % 2 == 0) ? amp : -amp), 1'b0);
    end
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    hold_until_drained();
  endtask

  task automatic send_random_series();
    int  kind;
    int  len;
    int  k;
    int  v;
    int  amp;
    bit  up;
    bit  eos;
    kind = $urandom_range(9);
    len  = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    up   = $urandom_range(1);
    v    = $urandom_range(400) - 200;
    for (k = 0; k < len; k++) begin
      eos = (k == len - 1);
      if (kind < 6) begin
        amp = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(200);
        v = up ? amp : -amp;
        if ($urandom_range(15) == 0) v = up ? 32767 : -32768;
        up = !up;
      end else if (kind < 9) begin
        if ($urandom_range(3) != 0) v = v + $urandom_range(100) - 50;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end else begin
        v = $urandom_range(65535) - 32768;
        if ($urandom_range(5) == 0) eos = 1'b1;
      end
      send_sample(rcc_pkg::sample_t'(v), eos);
    end
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    int stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_random_series();
    hold_until_drained();
  endtask

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sample_i        = '0;
    end_of_series_i = 1'b0;
    out_ready_i     = 1'b0;
    turn_cnt        = 0;
    prior_val       = 0;
    cand_val        = 0;
    seen_cnt        = 0;
    ovf_flag        = 1'b0;
    err_cnt         = 0;
    items_sent      = 0;
    cycles_seen     = 0;
    full_seen       = 0;
    ovf_results     = 0;
    send_idle_pct   = 32;
    recv_idle_pct   = 64;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_single_samples();
    test_extremes();
    test_flat_stretches();
    test_cycle_rules();
    hold_until_drained();
    test_stack_overflow();
    test_random(50, 32, 64);
    test_random(50, 64, 32);
    test_random(40, 0, 0);

    hold_until_drained();
    repeat (40) @(negedge clk_i);
    $display("Summary: %0d samples sent under three idle mixes, %0d cycles checked",
             items_sent, cycles_seen);
    $display("Summary: %0d full cycles, %0d results flagged stack overflow",
             full_seen, ovf_results);
    if (err_cnt == 0 && cycle_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
